// ===== hw/rtl/flwseq_pkg.sv =====
`default_nettype none
package flwseq_pkg;

	localparam int unsigned FLASH_BYTES   = 16777216;
	localparam int unsigned SECTOR_BYTES  = 4096;
	localparam int unsigned PAGE_BYTES    = 256;
	localparam int unsigned SECTOR_TOTAL  = 4096;
	localparam int unsigned SAMPLE_BYTES  = 32;
	localparam int unsigned ENTRY_BYTES   = 4;
	localparam int unsigned SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
	localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);

	localparam logic [11:0] FRESH_ERASED_SECTOR = 12'd2;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_STOP   = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;

	localparam logic [2:0] PH_WRITE      = 3'd0;
	localparam logic [2:0] PH_ERASE      = 3'd1;
	localparam logic [2:0] PH_FULL_TABLE = 3'd2;
	localparam logic [2:0] PH_FULL_D1    = 3'd3;
	localparam logic [2:0] PH_FULL_D2    = 3'd4;

	localparam logic [1:0] RQ_NONE  = 2'd0;
	localparam logic [1:0] RQ_START = 2'd1;
	localparam logic [1:0] RQ_ERASE = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;
	localparam logic [1:0] CMD_ENTRY = 2'd3;

	localparam logic CFG_DATA_HEAD  = 1'b0;
	localparam logic CFG_TABLE_HEAD = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic        flash_busy;
		logic        flash_status_error;
		logic [12:0] buffered_bytes;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [23:0] flash_address;
		logic [8:0]  program_length;
		logic [24:0] entry_value;
		logic        flash_full;
		logic        capture_active;
		logic        writes_pending;
	} out_item_t;

	typedef struct packed {
		logic [24:0] data_head;
		logic [12:0] table_head;
		logic [11:0] last_erased_sector;
		logic [2:0]  phase;
		logic        active_flag;
		logic        pending_flag;
		logic [1:0]  pending_request;
		logic        full_flag;
	} seq_state_t;

	typedef struct packed {
		logic [24:0] data_head;
		logic [12:0] table_head;
	} recovered_t;

endpackage
`default_nettype wire

// ===== hw/rtl/flwseq_step.sv =====
`default_nettype none
module flwseq_step (
	input  wire flwseq_pkg::seq_state_t cur,
	input  wire flwseq_pkg::recovered_t rec,
	input  wire flwseq_pkg::in_item_t   item,
	output flwseq_pkg::seq_state_t      nxt,
	output flwseq_pkg::out_item_t       res
);

	always_comb begin
		logic        busy;
		logic [12:0] final_sector;
		logic [12:0] les_inc;
		logic [24:0] free_bytes;
		logic [8:0]  page_room;
		logic [12:0] chunk;
		logic [13:0] table_end;
		logic [24:0] dh_sat;
		logic [12:0] sec;

		nxt = cur;
		res = '0;
		busy = item.flash_busy | item.flash_status_error;
		final_sector = 13'((cur.data_head + 25'(flwseq_pkg::SAMPLE_BYTES - 1))
			>> flwseq_pkg::SECTOR_SHIFT);
		les_inc = {1'b0, cur.last_erased_sector} + 13'd1;
		free_bytes = (cur.data_head >= 25'(flwseq_pkg::FLASH_BYTES)) ? 25'd0 :
			25'(flwseq_pkg::FLASH_BYTES) - cur.data_head;
		page_room = 9'(flwseq_pkg::PAGE_BYTES)
			- 9'(cur.data_head[flwseq_pkg::PAGE_SHIFT-1:0]);
		table_end = {1'b0, cur.table_head} + 14'(flwseq_pkg::ENTRY_BYTES);
		dh_sat = (rec.data_head > 25'(flwseq_pkg::FLASH_BYTES)) ?
			25'(flwseq_pkg::FLASH_BYTES) : rec.data_head;
		sec = 13'(dh_sat >> flwseq_pkg::SECTOR_SHIFT) + 13'd1;

		chunk = 13'(page_room);
		if (25'(page_room) > free_bytes) begin
			chunk = 13'(free_bytes);
		end
		if (free_bytes < 25'(flwseq_pkg::SAMPLE_BYTES)) begin
			chunk = '0;
		end
		if (chunk > item.buffered_bytes) begin
			chunk = item.buffered_bytes;
		end

		unique case (item.operation)
			flwseq_pkg::OP_TICK: begin
				if (!busy) begin
					unique case (cur.phase)
						flwseq_pkg::PH_WRITE: begin
							if (final_sector >= {1'b0, cur.last_erased_sector} &&
								les_inc < 13'(flwseq_pkg::SECTOR_TOTAL)) begin
								nxt.phase = flwseq_pkg::PH_ERASE;
								res.command = flwseq_pkg::CMD_ERASE;
								res.flash_address = 24'(les_inc) << flwseq_pkg::SECTOR_SHIFT;
							end else begin
								if (free_bytes < 25'(flwseq_pkg::SAMPLE_BYTES)) begin
									nxt.full_flag = 1'b1;
								end
								if (chunk != '0) begin
									nxt.data_head = cur.data_head + 25'(chunk);
									res.command = flwseq_pkg::CMD_DATA;
									res.flash_address = cur.data_head[23:0];
									res.program_length = 9'(chunk);
								end else if (!cur.active_flag && cur.pending_flag) begin
									nxt.pending_flag = 1'b0;
								end else if (cur.pending_request == flwseq_pkg::RQ_START) begin
									nxt.pending_request = flwseq_pkg::RQ_NONE;
									if (table_end > 14'(flwseq_pkg::SECTOR_BYTES)) begin
										nxt.full_flag = 1'b1;
									end else begin
										nxt.table_head = table_end[12:0];
										res.command = flwseq_pkg::CMD_ENTRY;
										res.flash_address = 24'(cur.table_head);
										res.program_length = 9'(flwseq_pkg::ENTRY_BYTES);
										res.entry_value = cur.data_head;
									end
								end else if (cur.pending_request == flwseq_pkg::RQ_ERASE) begin
									nxt.pending_request = flwseq_pkg::RQ_NONE;
									nxt.last_erased_sector = flwseq_pkg::FRESH_ERASED_SECTOR;
									nxt.table_head = '0;
									nxt.data_head = 25'(flwseq_pkg::SECTOR_BYTES);
									nxt.phase = flwseq_pkg::PH_FULL_TABLE;
									res.command = flwseq_pkg::CMD_ERASE;
								end
							end
						end
						flwseq_pkg::PH_FULL_TABLE: begin
							nxt.phase = flwseq_pkg::PH_FULL_D1;
							res.command = flwseq_pkg::CMD_ERASE;
							res.flash_address = 24'(flwseq_pkg::SECTOR_BYTES);
						end
						flwseq_pkg::PH_FULL_D1: begin
							nxt.phase = flwseq_pkg::PH_FULL_D2;
							res.command = flwseq_pkg::CMD_ERASE;
							res.flash_address = 24'(2 * flwseq_pkg::SECTOR_BYTES);
						end
						flwseq_pkg::PH_FULL_D2: begin
							nxt.phase = flwseq_pkg::PH_WRITE;
						end
						default: begin
							nxt.last_erased_sector = les_inc[11:0];
							nxt.phase = flwseq_pkg::PH_WRITE;
						end
					endcase
				end
			end
			flwseq_pkg::OP_START: begin
				if (!cur.active_flag) begin
					nxt.active_flag = 1'b1;
					nxt.pending_flag = 1'b1;
					nxt.pending_request = flwseq_pkg::RQ_START;
				end
			end
			flwseq_pkg::OP_STOP: begin
				nxt.active_flag = 1'b0;
			end
			flwseq_pkg::OP_ERASE: begin
				nxt.pending_request = flwseq_pkg::RQ_ERASE;
			end
			flwseq_pkg::OP_RESUME: begin
				nxt.data_head = dh_sat;
				nxt.table_head = (rec.table_head > 13'(flwseq_pkg::SECTOR_BYTES)) ?
					13'(flwseq_pkg::SECTOR_BYTES) : rec.table_head;
				nxt.last_erased_sector = (sec > 13'(flwseq_pkg::SECTOR_TOTAL - 1)) ?
					12'(flwseq_pkg::SECTOR_TOTAL - 1) : sec[11:0];
				nxt.phase = flwseq_pkg::PH_WRITE;
				nxt.active_flag = 1'b0;
				nxt.pending_flag = 1'b0;
				nxt.pending_request = flwseq_pkg::RQ_NONE;
				if (dh_sat + 25'(flwseq_pkg::SAMPLE_BYTES) >= 25'(flwseq_pkg::FLASH_BYTES)) begin
					nxt.full_flag = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.flash_full = nxt.full_flag;
		res.capture_active = nxt.active_flag;
		res.writes_pending = nxt.active_flag | nxt.pending_flag;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/flash_log_write_sequencer_unit.sv =====
// Write sequencer for a capture log in NOR flash. Each accepted word (a tick or an event)
// produces exactly one result word, valid from the cycle after it is accepted. While results
// are taken as they appear, a new word is accepted every cycle: the whole decision is one
// pass of logic between the state registers and the single result register. A result that
// is held off stalls the input until it is taken. Configuration writes load the recovered
// heads used by resume and should be made while the block is idle.
`default_nettype none
module flash_log_write_sequencer_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire flwseq_pkg::in_item_t  in_item,
	output logic                       out_valid,
	input  wire                        out_stall,
	output flwseq_pkg::out_item_t      out_item,
	input  wire                        cfg_write,
	input  wire                        cfg_index,
	input  wire [24:0]                 cfg_data
);

	flwseq_pkg::seq_state_t state_q;
	flwseq_pkg::seq_state_t state_nxt;
	flwseq_pkg::recovered_t rec_q;
	flwseq_pkg::out_item_t  res;
	flwseq_pkg::out_item_t  out_item_q;
	logic                   out_valid_q;
	logic                   accept;

	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	flwseq_step u_step (
		.cur  (state_q),
		.rec  (rec_q),
		.item (in_item),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.data_head <= 25'(flwseq_pkg::SECTOR_BYTES);
			rec_q.table_head <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				flwseq_pkg::CFG_DATA_HEAD:  rec_q.data_head <= cfg_data;
				flwseq_pkg::CFG_TABLE_HEAD: rec_q.table_head <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.data_head <= 25'(flwseq_pkg::SECTOR_BYTES);
			state_q.table_head <= '0;
			state_q.last_erased_sector <= flwseq_pkg::FRESH_ERASED_SECTOR;
			state_q.phase <= flwseq_pkg::PH_WRITE;
			state_q.active_flag <= 1'b0;
			state_q.pending_flag <= 1'b0;
			state_q.pending_request <= flwseq_pkg::RQ_NONE;
			state_q.full_flag <= 1'b0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/flwseq_checker.sv =====
`default_nettype none
module flwseq_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        out_valid,
	input wire                        out_stall,
	input wire flwseq_pkg::out_item_t out_item
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("Stalled result word changed or vanished.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command == flwseq_pkg::CMD_NONE |->
		out_item.flash_address == '0 && out_item.program_length == '0 &&
		out_item.entry_value == '0)
		else $error("Idle result carries a nonzero address, length or entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command == flwseq_pkg::CMD_ERASE |->
		out_item.flash_address[flwseq_pkg::SECTOR_SHIFT-1:0] == '0 &&
		out_item.program_length == '0)
		else $error("Erase is not sector aligned or has a length.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command == flwseq_pkg::CMD_DATA |->
		out_item.program_length != '0 &&
		out_item.program_length <= 9'(flwseq_pkg::PAGE_BYTES))
		else $error("Data program length out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command == flwseq_pkg::CMD_ENTRY |->
		out_item.program_length == 9'(flwseq_pkg::ENTRY_BYTES))
		else $error("File entry program has the wrong length.");

endmodule

bind flash_log_write_sequencer_unit flwseq_checker u_flwseq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire

// ===== verif/flash_log_write_sequencer_unit_tb.sv =====
module flash_log_write_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import flwseq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_WORDS = 125;
	localparam int unsigned MISMATCH_REPORTS = 10;

	class sequencer_scoreboard;
		out_item_t predicted_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned full_words;
		int unsigned commands_seen[4];
		int unsigned saved_data_head;
		int unsigned saved_table_head;
		int unsigned data_head;
		int unsigned table_head;
		int unsigned erased_sector;
		logic [2:0] phase;
		logic [1:0] request;
		bit active;
		bit pending;
		bit full;

		function new();
			saved_data_head = SECTOR_BYTES;
			saved_table_head = 0;
			data_head = SECTOR_BYTES;
			table_head = 0;
			erased_sector = 32'(FRESH_ERASED_SECTOR);
			phase = PH_WRITE;
			request = RQ_NONE;
			active = 0;
			pending = 0;
			full = 0;
		endfunction

		function void set_register(logic index, logic [24:0] value);
			if (index == CFG_DATA_HEAD) begin
				saved_data_head = 32'(value);
			end else begin
				saved_table_head = 32'(value[12:0]);
			end
		endfunction

		function out_item_t predict_command(in_item_t w);
			out_item_t r;
			int unsigned last_sector;
			int unsigned free_bytes;
			int unsigned chunk;
			int unsigned sector;
			int unsigned address;
			int unsigned length;
			int unsigned value;
			logic [1:0] command;
			command = CMD_NONE;
			address = 0;
			length = 0;
			value = 0;
			case (w.operation)
				OP_TICK: begin
					if (!(w.flash_busy || w.flash_status_error)) begin
						case (phase)
							PH_WRITE: begin
								last_sector = (data_head + SAMPLE_BYTES - 1) / SECTOR_BYTES;
								if (last_sector >= erased_sector
										&& erased_sector + 1 < SECTOR_TOTAL) begin
									phase = PH_ERASE;
									command = CMD_ERASE;
									address = (erased_sector + 1) * SECTOR_BYTES;
								end else begin
									free_bytes = (data_head >= FLASH_BYTES) ? 0
										: FLASH_BYTES - data_head;
									chunk = PAGE_BYTES - data_head % PAGE_BYTES;
									if (chunk > free_bytes) chunk = free_bytes;
									if (free_bytes < SAMPLE_BYTES) begin
										chunk = 0;
										full = 1;
									end
									if (chunk > w.buffered_bytes) chunk = 32'(w.buffered_bytes);
									if (chunk != 0) begin
										command = CMD_DATA;
										address = data_head;
										length = chunk;
										data_head += chunk;
									end else if (!active && pending) begin
										pending = 0;
									end else if (request == RQ_START) begin
										request = RQ_NONE;
										if (table_head + ENTRY_BYTES > SECTOR_BYTES) begin
											full = 1;
										end else begin
											command = CMD_ENTRY;
											address = table_head;
											length = ENTRY_BYTES;
											value = data_head;
											table_head += ENTRY_BYTES;
										end
									end else if (request == RQ_ERASE) begin
										request = RQ_NONE;
										erased_sector = 32'(FRESH_ERASED_SECTOR);
										table_head = 0;
										data_head = SECTOR_BYTES;
										phase = PH_FULL_TABLE;
										command = CMD_ERASE;
									end
								end
							end
							PH_FULL_TABLE: begin
								phase = PH_FULL_D1;
								command = CMD_ERASE;
								address = SECTOR_BYTES;
							end
							PH_FULL_D1: begin
								phase = PH_FULL_D2;
								command = CMD_ERASE;
								address = 2 * SECTOR_BYTES;
							end
							PH_FULL_D2: begin
								phase = PH_WRITE;
							end
							default: begin
								erased_sector += 1;
								phase = PH_WRITE;
							end
						endcase
					end
				end
				OP_START: begin
					if (!active) begin
						active = 1;
						pending = 1;
						request = RQ_START;
					end
				end
				OP_STOP: active = 0;
				OP_ERASE: request = RQ_ERASE;
				OP_RESUME: begin
					data_head = (saved_data_head > FLASH_BYTES) ? FLASH_BYTES : saved_data_head;
					table_head = (saved_table_head > SECTOR_BYTES) ? SECTOR_BYTES
						: saved_table_head;
					sector = data_head / SECTOR_BYTES + 1;
					erased_sector = (sector > SECTOR_TOTAL - 1) ? SECTOR_TOTAL - 1 : sector;
					phase = PH_WRITE;
					active = 0;
					pending = 0;
					request = RQ_NONE;
					if (data_head + SAMPLE_BYTES >= FLASH_BYTES) full = 1;
				end
				default: ;
			endcase
			r.command = command;
			r.flash_address = address[23:0];
			r.program_length = length[8:0];
			r.entry_value = value[24:0];
			r.flash_full = full;
			r.capture_active = active;
			r.writes_pending = active || pending;
			return r;
		endfunction

		function void note_word(in_item_t w);
			predicted_results.push_back(predict_command(w));
		endfunction

		function void check_word(out_item_t got);
			out_item_t want;
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_REPORTS)
					$display("Result word arrived with nothing expected: %p", got);
				return;
			end
			want = predicted_results.pop_front();
			checked++;
			if (got.command !== want.command || got.flash_address !== want.flash_address
					|| got.program_length !== want.program_length
					|| got.entry_value !== want.entry_value
					|| got.flash_full !== want.flash_full
					|| got.capture_active !== want.capture_active
					|| got.writes_pending !== want.writes_pending) begin
				mismatches++;
				if (mismatches <= MISMATCH_REPORTS)
					$display("Word %0d differs: expected %p, got %p", checked, want, got);
			end else begin
				commands_seen[got.command]++;
				if (got.flash_full) full_words++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_write;
	logic cfg_index;
	logic [24:0] cfg_data;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned cycle_count;
	bit hold_request;
	sequencer_scoreboard sb = new();

	flash_log_write_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_word(out_item);
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic in_item_t word(logic [2:0] op, logic busy, logic err,
			logic [12:0] bytes);
		in_item_t w;
		w.operation = op;
		w.flash_busy = busy;
		w.flash_status_error = err;
		w.buffered_bytes = bytes;
		return w;
	endfunction

	function automatic in_item_t random_word();
		in_item_t w;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 68) w.operation = OP_TICK;
		else if (pick < 77) w.operation = OP_START;
		else if (pick < 85) w.operation = OP_STOP;
		else if (pick < 88) w.operation = OP_ERASE;
		else if (pick < 91) w.operation = OP_RESUME;
		else w.operation = OP_RESUME + 3'($urandom_range(1, 3));
		w.flash_busy = ($urandom_range(0, 99) < 10);
		w.flash_status_error = ($urandom_range(0, 99) < 5);
		pick = $urandom_range(0, 99);
		if (pick < 25) w.buffered_bytes = '0;
		else if (pick < 50) w.buffered_bytes = 13'($urandom_range(1, 40));
		else if (pick < 80) w.buffered_bytes = 13'($urandom_range(0, 300));
		else if (pick < 95) w.buffered_bytes = 13'($urandom_range(0, 4096));
		else w.buffered_bytes = 13'($urandom);
		return w;
	endfunction

	task automatic send_word(input in_item_t w);
		int unsigned gap;
		gap = 0;
		in_valid <= 1'b1;
		in_item <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(w);
		while ($urandom_range(0, 99) < idle_pct && gap < 200) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_words(input int unsigned count);
		in_item_t w;
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			w = random_word();
			send_word(w);
			if (w.operation <= OP_RESUME) sent++;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.predicted_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_recovered(input logic [24:0] data_head, input logic [12:0] table_head);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DATA_HEAD;
		cfg_data <= data_head;
		@(posedge clk);
		sb.set_register(CFG_DATA_HEAD, data_head);
		cfg_index <= CFG_TABLE_HEAD;
		cfg_data <= {12'd0, table_head};
		@(posedge clk);
		sb.set_register(CFG_TABLE_HEAD, {12'd0, table_head});
		cfg_write <= 1'b0;
	endtask

	task automatic start_phase(input int unsigned sender_idle, input int unsigned receiver_stall,
			input logic [24:0] data_head, input logic [12:0] table_head);
		settle();
		load_recovered(data_head, table_head);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		send_word(word(OP_RESUME, 1'b0, 1'b0, '0));
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_DATA_HEAD;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_recovered(25'(FLASH_BYTES - 48), 13'd4092);

		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b1, 1'b0, 13'd4096));
		send_word(word(OP_TICK, 1'b0, 1'b1, 13'd4096));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'h1FFF));
		send_word(word(OP_START, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_START, 1'b1, 1'b1, 13'h1FFF));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd5));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd4096));
		send_word(word(OP_STOP, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_RESUME + 3'd3, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_ERASE, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b1, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_RESUME, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_START, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd4096));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd100));
		send_word(word(OP_STOP, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_START, 1'b0, 1'b0, 13'd0));
		send_word(word(OP_TICK, 1'b0, 1'b0, 13'd0));
		random_words(PHASE_WORDS);

		start_phase(88, 0, 25'd0, 13'd0);
		random_words(PHASE_WORDS);

		start_phase(0, 88, 25'h1FFFFFF, 13'h1FFF);
		random_words(PHASE_WORDS);

		start_phase(9, 9, 25'd12272, 13'd4096);
		random_words(PHASE_WORDS);

		start_phase(0, 0, 25'($urandom_range(0, FLASH_BYTES)), 13'($urandom_range(0, 4096)));
		hold_request = 1;
		random_words(PHASE_WORDS);

		settle();
		$display("Checked %0d result words in five traffic phases,", sb.checked);
		$display("one of them with a %0d-cycle output hold.", HOLD_CYCLES);
		$display("Commands: %0d none, %0d erase, %0d data, %0d entry; %0d words flagged full.",
			sb.commands_seen[CMD_NONE], sb.commands_seen[CMD_ERASE],
			sb.commands_seen[CMD_DATA], sb.commands_seen[CMD_ENTRY], sb.full_words);
		if (sb.mismatches == 0 && sb.predicted_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/flwseq_pkg.sv
hw/rtl/flwseq_step.sv
hw/rtl/flash_log_write_sequencer_unit.sv
hw/rtl/flwseq_checker.sv
verif/flash_log_write_sequencer_unit_tb.sv
